### rtl/date_time_set_editor_top_assert.svh
// assertion macros used by the date and time editor checker
`ifndef DATE_TIME_SET_EDITOR_TOP_ASSERT_SVH
`define DATE_TIME_SET_EDITOR_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define DTSE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("date_time_set_editor check failed");

// antecedent implies consequent in the next cycle
`define DTSE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("date_time_set_editor check failed");

`endif

### rtl/dtse_pkg.sv
// types, codes and calendar helpers for the date and time editor
`default_nettype none
package dtse_pkg;

    localparam int CUR_W   = 3;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 12;
    localparam int OP_W    = 3;
    localparam int CFG_IDX_W = 2;

    // event codes
    localparam logic [OP_W-1:0] OP_UP    = 3'd0;
    localparam logic [OP_W-1:0] OP_DOWN  = 3'd1;
    localparam logic [OP_W-1:0] OP_LEFT  = 3'd2;
    localparam logic [OP_W-1:0] OP_RIGHT = 3'd3;
    localparam logic [OP_W-1:0] OP_LOAD  = 3'd4;

    // cursor positions
    localparam logic [CUR_W-1:0] CUR_HOUR   = 3'd0;
    localparam logic [CUR_W-1:0] CUR_MINUTE = 3'd1;
    localparam logic [CUR_W-1:0] CUR_SECOND = 3'd2;
    localparam logic [CUR_W-1:0] CUR_DAY    = 3'd3;
    localparam logic [CUR_W-1:0] CUR_MONTH  = 3'd4;
    localparam logic [CUR_W-1:0] CUR_YEAR   = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_YEAR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_YEAR = 2'd1;

    localparam logic [YEAR_W-1:0] MIN_YEAR_RST = 12'd2012;
    localparam logic [YEAR_W-1:0] MAX_YEAR_RST = 12'd2100;

    localparam logic [HOUR_W-1:0]  HOUR_MAX  = 5'd23;
    localparam logic [MIN_W-1:0]   MIN_MAX   = 6'd59;
    localparam logic [SEC_W-1:0]   SEC_MAX   = 6'd59;
    localparam logic [MONTH_W-1:0] MONTH_MAX = 4'd12;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;

    typedef struct packed {
        logic [CUR_W-1:0]   cursor;
        logic [HOUR_W-1:0]  hours;
        logic [MIN_W-1:0]   minutes;
        logic [SEC_W-1:0]   seconds;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } t_state;

    typedef struct packed {
        logic [HOUR_W-1:0]  hours;
        logic [MIN_W-1:0]   minutes;
        logic [SEC_W-1:0]   seconds;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } t_load;

    localparam t_state STATE_RST = '{
        cursor:  CUR_HOUR,
        hours:   '0,
        minutes: '0,
        seconds: '0,
        day:     5'd1,
        month:   4'd1,
        year:    MIN_YEAR_RST
    };

    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        return (y[1:0] == 2'b00);
    endfunction

    // days in month, out of range months count as january
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic [YEAR_W-1:0] y);
        logic [DAY_W-1:0] len;
        unique case (m)
            MONTH_FEB:                   len = is_leap(y) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:     len = 5'd30;
            default:                     len = 5'd31;
        endcase
        return len;
    endfunction

endpackage
`default_nettype wire

### rtl/dtse_if.sv
// handshake channels of the date and time editor
`default_nettype none
interface dtse_in_if;
    logic                            valid;
    logic                            ready;
    logic [dtse_pkg::OP_W-1:0]       opcode;
    logic [dtse_pkg::HOUR_W-1:0]     load_hours;
    logic [dtse_pkg::MIN_W-1:0]      load_minutes;
    logic [dtse_pkg::SEC_W-1:0]      load_seconds;
    logic [dtse_pkg::DAY_W-1:0]      load_day;
    logic [dtse_pkg::MONTH_W-1:0]    load_month;
    logic [dtse_pkg::YEAR_W-1:0]     load_year;

    modport source (output valid, opcode, load_hours, load_minutes, load_seconds,
                    load_day, load_month, load_year, input ready);
    modport sink (input valid, opcode, load_hours, load_minutes, load_seconds,
                  load_day, load_month, load_year, output ready);
endinterface

interface dtse_out_if;
    logic                            valid;
    logic                            ready;
    logic [dtse_pkg::CUR_W-1:0]      field_cursor;
    logic [dtse_pkg::HOUR_W-1:0]     hours;
    logic [dtse_pkg::MIN_W-1:0]      minutes;
    logic [dtse_pkg::SEC_W-1:0]      seconds;
    logic [dtse_pkg::DAY_W-1:0]      day_of_month;
    logic [dtse_pkg::MONTH_W-1:0]    month_number;
    logic [dtse_pkg::YEAR_W-1:0]     year_number;
    logic                            leap_year;

    modport source (output valid, field_cursor, hours, minutes, seconds, day_of_month,
                    month_number, year_number, leap_year, input ready);
    modport sink (input valid, field_cursor, hours, minutes, seconds, day_of_month,
                  month_number, year_number, leap_year, output ready);
endinterface

interface dtse_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [dtse_pkg::CFG_IDX_W-1:0]  index;
    logic [dtse_pkg::YEAR_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/dtse_step.sv
// next state of the editor for one button event
`default_nettype none
module dtse_step (
    input  logic [dtse_pkg::OP_W-1:0]   i_opcode,
    input  dtse_pkg::t_load             i_load,
    input  dtse_pkg::t_state            i_cur,
    input  logic [dtse_pkg::YEAR_W-1:0] i_min_year,
    input  logic [dtse_pkg::YEAR_W-1:0] i_max_year,
    output dtse_pkg::t_state            o_next
);
    import dtse_pkg::*;

    t_state            nx;
    logic              do_clamp;
    logic              up;
    logic [DAY_W-1:0]  len_cur;
    logic [DAY_W-1:0]  len_nx;

    assign up      = (i_opcode == OP_UP);
    assign len_cur = month_len(i_cur.month, i_cur.year);

    always_comb begin
        nx       = i_cur;
        do_clamp = 1'b0;
        unique case (i_opcode)
            OP_UP, OP_DOWN: begin
                unique case (i_cur.cursor)
                    CUR_HOUR: begin
                        if (up) begin
                            nx.hours = (i_cur.hours >= HOUR_MAX) ? '0 : i_cur.hours + 1'b1;
                        end else begin
                            nx.hours = (i_cur.hours == '0 || i_cur.hours > HOUR_MAX)
                                       ? HOUR_MAX : i_cur.hours - 1'b1;
                        end
                    end
                    CUR_MINUTE: begin
                        if (up) begin
                            nx.minutes = (i_cur.minutes >= MIN_MAX) ? '0
                                         : i_cur.minutes + 1'b1;
                        end else begin
                            nx.minutes = (i_cur.minutes == '0 || i_cur.minutes > MIN_MAX)
                                         ? MIN_MAX : i_cur.minutes - 1'b1;
                        end
                    end
                    CUR_SECOND: begin
                        if (up) begin
                            nx.seconds = (i_cur.seconds >= SEC_MAX) ? '0
                                         : i_cur.seconds + 1'b1;
                        end else begin
                            nx.seconds = (i_cur.seconds == '0 || i_cur.seconds > SEC_MAX)
                                         ? SEC_MAX : i_cur.seconds - 1'b1;
                        end
                    end
                    CUR_DAY: begin
                        if (up) begin
                            nx.day = (i_cur.day >= len_cur || i_cur.day == '0) ? 5'd1
                                     : i_cur.day + 1'b1;
                        end else begin
                            nx.day = (i_cur.day <= 5'd1 || i_cur.day > len_cur) ? len_cur
                                     : i_cur.day - 1'b1;
                        end
                    end
                    CUR_MONTH: begin
                        if (up) begin
                            nx.month = (i_cur.month >= MONTH_MAX || i_cur.month == '0)
                                       ? 4'd1 : i_cur.month + 1'b1;
                        end else begin
                            nx.month = (i_cur.month <= 4'd1 || i_cur.month > MONTH_MAX)
                                       ? MONTH_MAX : i_cur.month - 1'b1;
                        end
                        do_clamp = 1'b1;
                    end
                    default: begin
                        // year wraps between the configured bounds
                        if (up) begin
                            nx.year = (i_cur.year >= i_max_year) ? i_min_year
                                      : i_cur.year + 1'b1;
                        end else begin
                            nx.year = (i_cur.year <= i_min_year) ? i_max_year
                                      : i_cur.year - 1'b1;
                        end
                        do_clamp = 1'b1;
                    end
                endcase
            end
            OP_LEFT: begin
                nx.cursor = (i_cur.cursor == CUR_HOUR) ? CUR_YEAR : i_cur.cursor - 1'b1;
            end
            OP_RIGHT: begin
                nx.cursor = (i_cur.cursor >= CUR_YEAR) ? CUR_HOUR : i_cur.cursor + 1'b1;
            end
            OP_LOAD: begin
                nx.cursor  = CUR_HOUR;
                nx.hours   = (i_load.hours > HOUR_MAX) ? HOUR_MAX : i_load.hours;
                nx.minutes = (i_load.minutes > MIN_MAX) ? MIN_MAX : i_load.minutes;
                nx.seconds = (i_load.seconds > SEC_MAX) ? SEC_MAX : i_load.seconds;
                nx.month   = (i_load.month == '0) ? 4'd1
                             : ((i_load.month > MONTH_MAX) ? MONTH_MAX : i_load.month);
                nx.year    = i_load.year;
                nx.day     = i_load.day;
                do_clamp   = 1'b1;
            end
            default: begin
                // unused codes leave everything as is
            end
        endcase
    end

    assign len_nx = month_len(nx.month, nx.year);

    // day limited to the (new) month length and raised from 0 to 1 after month, year or load changes
    always_comb begin
        o_next = nx;
        if (do_clamp) begin
            if (nx.day > len_nx) begin
                o_next.day = len_nx;
            end else if (nx.day == '0) begin
                o_next.day = 5'd1;
            end
        end
    end

endmodule
`default_nettype wire

### rtl/date_time_set_editor_top.sv
// top level of the date and time editor
`default_nettype none
// button driven clock and calendar editor. each item on i_in is one button event
// (up, down, left, right or load) and produces exactly one item on o_out holding
// the cursor and all six fields after the event. the editor state and the result
// register both update at the accepting edge, so the result shows on o_out in the
// cycle after acceptance and a new item can be taken every cycle while o_out is
// not stalled. i_in.ready is high whenever the result register is empty or is
// being drained in the same cycle, so a stalled o_out holds its item and blocks
// only new input. min_year and max_year are written through i_cfg, which is always
// ready; writes to unknown indexes are ignored
module date_time_set_editor_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dtse_in_if.sink    i_in,
    dtse_out_if.source o_out,
    dtse_cfg_if.sink   i_cfg
);
    import dtse_pkg::*;

    // editor state and year bounds
    t_state            r_state;
    t_state            n_state;
    logic [YEAR_W-1:0] r_min_year;
    logic [YEAR_W-1:0] r_max_year;

    // result register
    t_state            r_res;
    logic              r_res_valid;

    t_load             load;
    logic              in_acc;

    assign load = '{
        hours:   i_in.load_hours,
        minutes: i_in.load_minutes,
        seconds: i_in.load_seconds,
        day:     i_in.load_day,
        month:   i_in.load_month,
        year:    i_in.load_year
    };

    // take a new item when the result slot is free or being emptied now
    assign i_in.ready = !r_res_valid || o_out.ready;
    assign in_acc     = i_in.valid && i_in.ready;

    dtse_step u_step (
        .i_opcode   (i_in.opcode),
        .i_load     (load),
        .i_cur      (r_state),
        .i_min_year (r_min_year),
        .i_max_year (r_max_year),
        .o_next     (n_state)
    );

    // editor state, updated only by accepted items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RST;
        end else if (in_acc) begin
            r_state <= n_state;
        end
    end

    // config registers, to be written only while idle; the block itself does not enforce this
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_year <= MIN_YEAR_RST;
            r_max_year <= MAX_YEAR_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            if (i_cfg.index == CFG_MIN_YEAR) begin
                r_min_year <= i_cfg.data;
            end else if (i_cfg.index == CFG_MAX_YEAR) begin
                r_max_year <= i_cfg.data;
            end
        end
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (in_acc) begin
            r_res_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_res <= n_state;
        end
    end

    assign o_out.valid        = r_res_valid;
    assign o_out.field_cursor = r_res.cursor;
    assign o_out.hours        = r_res.hours;
    assign o_out.minutes      = r_res.minutes;
    assign o_out.seconds      = r_res.seconds;
    assign o_out.day_of_month = r_res.day;
    assign o_out.month_number = r_res.month;
    assign o_out.year_number  = r_res.year;
    assign o_out.leap_year    = is_leap(r_res.year);

endmodule
`default_nettype wire

### rtl/dtse_checker.sv
// port level checks of the date and time editor, bound to the top level
`default_nettype none
`include "date_time_set_editor_top_assert.svh"
module dtse_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            i_in_ready,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic [dtse_pkg::CUR_W-1:0]      i_cursor,
    input logic [dtse_pkg::HOUR_W-1:0]     i_hours,
    input logic [dtse_pkg::MIN_W-1:0]      i_minutes,
    input logic [dtse_pkg::DAY_W-1:0]      i_day,
    input logic [dtse_pkg::MONTH_W-1:0]    i_month
);
    import dtse_pkg::*;

    // an accepted item shows its result in the next cycle
    `DTSE_ASSERT_NEXT(a_result_follows, i_in_valid && i_in_ready, i_out_valid)

    // a stalled result stays valid with cursor, day and month unchanged
    `DTSE_ASSERT_NEXT(a_stall_holds, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_cursor) && $stable(i_day) && $stable(i_month))

    // while o_out is valid, cursor, hours, minutes and month stay in range and day is nonzero
    `DTSE_ASSERT_SAME(a_time_range, i_out_valid,
        i_cursor <= CUR_YEAR && i_hours <= HOUR_MAX && i_minutes <= MIN_MAX)

    `DTSE_ASSERT_SAME(a_date_range, i_out_valid,
        i_day != '0 && i_month != '0 && i_month <= MONTH_MAX)

endmodule

bind date_time_set_editor_top dtse_checker u_dtse_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_cursor    (o_out.field_cursor),
    .i_hours     (o_out.hours),
    .i_minutes   (o_out.minutes),
    .i_day       (o_out.day_of_month),
    .i_month     (o_out.month_number)
);
`default_nettype wire
